@@ rtl/flash_log_key_value_store_unit_defines.svh @@
// assertion macros for the flash log key value store checker
// depends on a clk and an active low rst_n in the using scope
`ifndef FLASH_LOG_KEY_VALUE_STORE_UNIT_DEFINES_SVH
`define FLASH_LOG_KEY_VALUE_STORE_UNIT_DEFINES_SVH

// same-cycle implication
`define FLKV_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("flkv assertion failed");

// next-cycle implication
`define FLKV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("flkv assertion failed");

`endif

@@ rtl/flkv_pkg.sv @@
// shared constants, codes and types of the flash log key value store
// no dependencies
package flkv_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int FILL_W     = $clog2(SLOT_COUNT + 1);
  localparam int KEY_W      = 16;
  localparam int VAL_W      = 16;
  localparam int SLOT_W     = KEY_W + VAL_W;

  localparam logic [SLOT_W-1:0] ERASED_WORD = {SLOT_W{1'b1}};
  localparam logic [KEY_W-1:0]  ERASED_KEY  = {KEY_W{1'b1}};
  localparam logic [VAL_W-1:0]  ERASED_VAL  = {VAL_W{1'b1}};

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_PAGE_FULL = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [1:0]       status;
    logic [VAL_W-1:0] value;
  } res_t;

endpackage

@@ rtl/flkv_slot_ram.sv @@
// generic single port write, single port read memory with registered read data
// no dependencies
module flkv_slot_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/flkv_ctrl.sv @@
// sequencer of the store: fill count, backward key scan with one shared comparator, append
// depends on flkv_pkg and flkv_slot_ram
module flkv_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_op,
  input  logic [flkv_pkg::KEY_W-1:0] in_key,
  input  logic [flkv_pkg::VAL_W-1:0] in_write_value,
  output flkv_pkg::res_t            res,
  input  logic                      res_taken
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_STORE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  localparam logic [flkv_pkg::FILL_W-1:0] FILL_MAX = flkv_pkg::FILL_W'(flkv_pkg::SLOT_COUNT);

  logic [1:0]                       state_r, state_nxt;
  logic [1:0]                       op_r, op_nxt;
  logic [flkv_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [flkv_pkg::VAL_W-1:0]       wval_r, wval_nxt;
  logic [flkv_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [flkv_pkg::SLOT_AW-1:0]     idx_r, idx_nxt;
  logic [flkv_pkg::FILL_W-1:0]      left_r, left_nxt;
  logic                             pend_r, pend_nxt;
  logic [1:0]                       status_r, status_nxt;
  logic [flkv_pkg::VAL_W-1:0]       value_r, value_nxt;

  logic                             ram_we, ram_re;
  logic [flkv_pkg::SLOT_W-1:0]      ram_wdata, ram_rdata;

  logic                             accept;
  logic                             resolve;
  logic                             found;
  logic [flkv_pkg::VAL_W-1:0]       found_val;
  logic [1:0]                       cur_op;
  logic [flkv_pkg::VAL_W-1:0]       cur_wval;
  logic                             key_hit;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign key_hit  = pend_r && (ram_rdata[flkv_pkg::SLOT_W-1:flkv_pkg::VAL_W] == key_r);
  assign ram_wdata = {key_r, wval_r};

  flkv_slot_ram #(
    .DEPTH(flkv_pkg::SLOT_COUNT),
    .WIDTH(flkv_pkg::SLOT_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(fill_r[flkv_pkg::SLOT_AW-1:0]),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(idx_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    wval_nxt   = wval_r;
    fill_nxt   = fill_r;
    idx_nxt    = idx_r;
    left_nxt   = left_r;
    pend_nxt   = pend_r;
    status_nxt = status_r;
    value_nxt  = value_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    resolve    = 1'b0;
    found      = 1'b0;
    found_val  = '0;
    cur_op     = op_r;
    cur_wval   = wval_r;

    unique case (state_r)
      S_IDLE: begin
        cur_op   = in_op;
        cur_wval = in_write_value;
        if (accept) begin
          op_nxt   = in_op;
          key_nxt  = in_key;
          wval_nxt = in_write_value;
          unique case (in_op)
            flkv_pkg::OP_READ, flkv_pkg::OP_UPDATE: begin
              // erased key matches the erased tail of the page at once
              if ((in_key == flkv_pkg::ERASED_KEY) && (fill_r != FILL_MAX)) begin
                resolve   = 1'b1;
                found     = 1'b1;
                found_val = flkv_pkg::ERASED_VAL;
              end else begin
                idx_nxt   = fill_r[flkv_pkg::SLOT_AW-1:0] - flkv_pkg::SLOT_AW'(1);
                left_nxt  = fill_r;
                pend_nxt  = 1'b0;
                state_nxt = S_SCAN;
              end
            end
            flkv_pkg::OP_WRITE: begin
              state_nxt = S_STORE;
            end
            default: begin
              status_nxt = flkv_pkg::ST_OK;
              value_nxt  = '0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (key_hit) begin
          resolve   = 1'b1;
          found     = 1'b1;
          found_val = ram_rdata[flkv_pkg::VAL_W-1:0];
        end else if (left_r == '0) begin
          resolve = 1'b1;
        end else begin
          ram_re   = 1'b1;
          pend_nxt = 1'b1;
          idx_nxt  = idx_r - flkv_pkg::SLOT_AW'(1);
          left_nxt = left_r - flkv_pkg::FILL_W'(1);
        end
      end
      S_STORE: begin
        value_nxt = '0;
        if (fill_r == FILL_MAX) begin
          fill_nxt   = '0;
          status_nxt = flkv_pkg::ST_PAGE_FULL;
        end else begin
          ram_we     = 1'b1;
          status_nxt = flkv_pkg::ST_OK;
          // an all ones pair leaves the slot erased
          if (ram_wdata != flkv_pkg::ERASED_WORD) begin
            fill_nxt = fill_r + flkv_pkg::FILL_W'(1);
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_taken) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (resolve) begin
      if (cur_op == flkv_pkg::OP_READ) begin
        status_nxt = found ? flkv_pkg::ST_OK : flkv_pkg::ST_NOT_FOUND;
        value_nxt  = found ? found_val : '0;
        state_nxt  = S_DONE;
      end else if (found && (found_val == cur_wval)) begin
        status_nxt = flkv_pkg::ST_OK;
        value_nxt  = '0;
        state_nxt  = S_DONE;
      end else begin
        state_nxt = S_STORE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    key_r    <= key_nxt;
    wval_r   <= wval_nxt;
    idx_r    <= idx_nxt;
    left_r   <= left_nxt;
    status_r <= status_nxt;
    value_r  <= value_nxt;
  end

  assign res.valid  = (state_r == S_DONE);
  assign res.status = status_r;
  assign res.value  = value_r;

endmodule

@@ rtl/flash_log_key_value_store_unit.sv @@
// top level of the flash log key value store: sequencer plus result register
// depends on flkv_pkg and flkv_ctrl
//
// usage
// - input channel in_*: op (read, write, update), key, write_value; one word is taken
//   when in_valid is high and in_stall low
// - result channel out_*: status and read_value, one word per input word, in order
// - the page is a log of SLOT_COUNT slots kept in a memory; a fill count marks the
//   written part, so reset empties the page at once with no clearing pass
// - write: the accepted word passes the store state, then waits in the done state until
//   the output register takes its result; on a full page the page is emptied and the status is page full
// - read: a backward scan through the written slots of the memory, one slot per cycle
//   behind one registered read
// - update: a read scan followed by a write when the value differs or the
//   key is absent
// - one word is in work at a time, so a word is taken only after the previous one is done;
//   in_stall is high from accept until the result has moved into the output register
// - while out_stall holds a result, one more word may be taken and worked on; it
//   then waits in the sequencer until the output register frees
// - synchronous active low reset clears the page and both valid flags
module flash_log_key_value_store_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_op,
  input  logic [flkv_pkg::KEY_W-1:0] in_key,
  input  logic [flkv_pkg::VAL_W-1:0] in_write_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [flkv_pkg::VAL_W-1:0] out_read_value
);

  flkv_pkg::res_t             res;
  logic                       load;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r;
  logic [flkv_pkg::VAL_W-1:0] out_read_value_r;

  flkv_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_key        (in_key),
    .in_write_value(in_write_value),
    .res           (res),
    .res_taken     (load)
  );

  assign load          = res.valid && (!out_valid_r || !out_stall);
  assign out_valid_nxt = load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status_r     <= res.status;
      out_read_value_r <= res.value;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;

endmodule

@@ rtl/flkv_checker.sv @@
// port level checker of the flash log key value store, bound to the top level
// depends on flkv_pkg and flash_log_key_value_store_unit_defines.svh
`include "flash_log_key_value_store_unit_defines.svh"

module flkv_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_stall,
  input logic [1:0]                 in_op,
  input logic [flkv_pkg::KEY_W-1:0] in_key,
  input logic [flkv_pkg::VAL_W-1:0] in_write_value,
  input logic                       out_valid,
  input logic                       out_stall,
  input logic [1:0]                 out_status,
  input logic [flkv_pkg::VAL_W-1:0] out_read_value
);

  // held result word stays put
  `FLKV_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_status) && $stable(out_read_value))

  // stalled input word stays put
  `FLKV_ASSERT_NEXT(a_in_hold, in_valid && in_stall,
    in_valid && $stable(in_op) && $stable(in_key) && $stable(in_write_value))

  // one word in work at a time
  `FLKV_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  // value only comes with an ok status
  `FLKV_ASSERT_NOW(a_value_only_ok, out_valid && (out_status != flkv_pkg::ST_OK),
    out_read_value == '0)

  // no status code beyond page full
  `FLKV_ASSERT_NOW(a_status_range, out_valid,
    (out_status == flkv_pkg::ST_OK) || (out_status == flkv_pkg::ST_NOT_FOUND) ||
    (out_status == flkv_pkg::ST_PAGE_FULL))

endmodule

bind flash_log_key_value_store_unit flkv_checker u_flkv_checker (.*);
